/* rtl/core/rans_pkg.sv */
// Shared constants for the byte-wise rANS encoder.
// Used by the channel interfaces, the encoder core and its checker.
package rans_pkg;

  // Field widths of the input item and the result item
  localparam int ACT_W   = 2;
  localparam int SYM_W   = 8;
  localparam int FREQ_W  = 16;
  localparam int BYTE_W  = 8;
  localparam int STATE_W = 32;

  // Action codes of an input item
  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ENCODE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_FLUSH  = 2'd2;

  // Coder state after reset and after a flush
  localparam logic [STATE_W-1:0] STATE_FLOOR = 32'h0080_0000;

  // Renormalization and flush emit at most four bytes
  localparam int               BYTE_CNT_W = 3;
  localparam logic [BYTE_CNT_W-1:0] MAX_BYTES = 3'd4;
  localparam logic [BYTE_CNT_W-1:0] LAST_FLUSH_BYTE = 3'd3;

  // Restoring divider: two quotient bits per cycle over a 32-bit dividend
  localparam int DIV_BITS_PER_CYCLE = 2;
  localparam int DIV_CYCLES = STATE_W / DIV_BITS_PER_CYCLE;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Width of the renormalization bound, frequency shifted up by at most 32
  localparam int BOUND_W = 48;

endpackage

/* rtl/core/rans_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on rans_pkg for field widths.
interface rans_item_if;
  logic                           valid;
  logic                           ready;
  logic [rans_pkg::ACT_W-1:0]     action;
  logic [rans_pkg::SYM_W-1:0]     symbol;
  logic [rans_pkg::FREQ_W-1:0]    frequency;

  modport source (output valid, action, symbol, frequency, input ready);
  modport sink   (input valid, action, symbol, frequency, output ready);
endinterface

interface rans_result_if;
  logic                           valid;
  logic                           ready;
  logic [rans_pkg::BYTE_W-1:0]    out_byte;
  logic                           last;
  logic                           error;

  modport source (output valid, out_byte, last, error, input ready);
  modport sink   (input valid, out_byte, last, error, output ready);
endinterface

/* rtl/core/rans_byte_encoder.sv */
// Byte-wise rANS encoder: one item at a time. An encode runs the table read,
// the renormalization check with its emitted bytes, then a restoring divider
// that retires two quotient bits per cycle, and the state update. A
// zero-frequency symbol gives its error transaction, a flush its four bytes.
// Frequency and cumulative start share one synchronous table memory, read at
// the encoded symbol; encode items must arrive in reverse data order.
// Depends on rans_pkg and rans_if.
module rans_byte_encoder #(
  parameter int PRECISION_BITS = 15,
  parameter int ALPHABET_SIZE  = 256
) (
  input  logic             clk,
  input  logic             rst,
  rans_item_if.sink        items,
  rans_result_if.source    results
);
  import rans_pkg::*;

  localparam int AW = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
  localparam logic [SYM_W:0] ALPHA_LIM = (SYM_W+1)'(ALPHABET_SIZE);
  localparam int RENORM_SHIFT = 31 - PRECISION_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_RENORM, S_ERROR, S_DIVIDE, S_UPDATE, S_FLUSH
  } fsm_t;

  fsm_t                   fsm;
  logic [STATE_W-1:0]     coder_state;
  logic [FREQ_W-1:0]      load_sum;
  logic [STATE_W-1:0]     x;
  logic [FREQ_W-1:0]      f_reg;
  logic [FREQ_W-1:0]      c_reg;
  logic [BOUND_W-1:0]     xmax;
  logic [FREQ_W-1:0]      rem;
  logic [BYTE_CNT_W-1:0]  cnt;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic                   sym_ok;
  logic                   out_valid;
  logic [BYTE_W-1:0]      out_byte;
  logic                   out_last;
  logic                   out_error;

  // Table memory: frequency in the upper half, cumulative start in the lower
  logic [2*FREQ_W-1:0]    table_mem [ALPHABET_SIZE];
  logic [2*FREQ_W-1:0]    rd_data;

  logic                   fire;
  logic                   in_range;
  logic                   load_we;
  logic                   rd_en;
  logic [AW-1:0]          addr;
  logic [FREQ_W-1:0]      cum_wr;
  logic                   slot_free;
  logic                   emit;
  logic [STATE_W-1:0]     x_sh;
  logic                   renorm_go;
  logic                   renorm_more;
  logic [FREQ_W-1:0]      rem_next;
  logic [STATE_W-1:0]     x_next;

  assign items.ready     = (fsm == S_IDLE);
  assign results.valid   = out_valid;
  assign results.out_byte = out_byte;
  assign results.last    = out_last;
  assign results.error   = out_error;

  assign fire      = items.valid && items.ready;
  assign in_range  = ({1'b0, items.symbol} < ALPHA_LIM);
  assign addr      = items.symbol[AW-1:0];
  assign cum_wr    = (items.symbol == '0) ? '0 : load_sum;
  assign load_we   = fire && (items.action == ACT_LOAD) && in_range;
  assign rd_en     = fire && (items.action == ACT_ENCODE);
  assign slot_free = !out_valid || results.ready;

  // Renormalization test on the current state and one byte ahead
  assign x_sh        = x >> BYTE_W;
  assign renorm_go   = (BOUND_W'(x) >= xmax) && (cnt != MAX_BYTES);
  assign renorm_more = (BOUND_W'(x_sh) >= xmax) && (cnt != LAST_FLUSH_BYTE);

  // A new result transaction is loaded into the output register this cycle
  assign emit = slot_free && ((fsm == S_ERROR) || (fsm == S_FLUSH)
                              || ((fsm == S_RENORM) && renorm_go));

  // Two restoring division steps per cycle
  always_comb begin
    logic [FREQ_W:0]    t;
    logic [FREQ_W-1:0]  r;
    logic [STATE_W-1:0] q;
    r = rem;
    q = x;
    for (int i = 0; i < DIV_BITS_PER_CYCLE; i++) begin
      t = {r, q[STATE_W-1]};
      q = {q[STATE_W-2:0], 1'b0};
      if (t >= {1'b0, f_reg}) begin
        t    = t - {1'b0, f_reg};
        q[0] = 1'b1;
      end
      r = t[FREQ_W-1:0];
    end
    rem_next = r;
    x_next   = q;
  end

  // Write loaded entries, read the entry of the symbol being encoded
  always_ff @(posedge clk) begin
    if (load_we) begin
      table_mem[addr] <= {items.frequency, cum_wr};
    end
    if (rd_en) begin
      rd_data <= table_mem[addr];
    end
  end

  // Sequencer, coder state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm         <= S_IDLE;
      out_valid   <= 1'b0;
      coder_state <= STATE_FLOOR;
      load_sum    <= '0;
    end else begin
      // Raise valid on an emit, drop it once the transaction is taken
      if (emit) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (fsm)
        S_IDLE: begin
          if (fire) begin
            case (items.action)
              ACT_LOAD: begin
                if (in_range) begin
                  load_sum <= cum_wr + items.frequency;
                end
              end
              ACT_ENCODE: begin
                sym_ok <= in_range;
                fsm    <= S_SETUP;
              end
              ACT_FLUSH: begin
                x   <= coder_state;
                cnt <= '0;
                fsm <= S_FLUSH;
              end
              default: ;
            endcase
          end
        end
        S_SETUP: begin
          f_reg <= rd_data[2*FREQ_W-1:FREQ_W];
          c_reg <= rd_data[FREQ_W-1:0];
          xmax  <= BOUND_W'(rd_data[2*FREQ_W-1:FREQ_W]) << RENORM_SHIFT;
          x     <= coder_state;
          cnt   <= '0;
          if (!sym_ok || (rd_data[2*FREQ_W-1:FREQ_W] == '0)) begin
            fsm <= S_ERROR;
          end else begin
            fsm <= S_RENORM;
          end
        end
        S_ERROR: begin
          if (slot_free) begin
            out_byte  <= '0;
            out_last  <= 1'b1;
            out_error <= 1'b1;
            fsm       <= S_IDLE;
          end
        end
        S_RENORM: begin
          if (renorm_go) begin
            if (slot_free) begin
              out_byte  <= x[BYTE_W-1:0];
              out_last  <= !renorm_more;
              out_error <= 1'b0;
              x         <= x_sh;
              cnt       <= cnt + 1'b1;
            end
          end else begin
            rem     <= '0;
            div_cnt <= '0;
            fsm     <= S_DIVIDE;
          end
        end
        S_DIVIDE: begin
          x       <= x_next;
          rem     <= rem_next;
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            fsm <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          coder_state <= STATE_W'(x << PRECISION_BITS) + STATE_W'(rem)
                         + STATE_W'(c_reg);
          fsm         <= S_IDLE;
        end
        S_FLUSH: begin
          if (slot_free) begin
            out_byte  <= x[BYTE_W-1:0];
            out_last  <= (cnt == LAST_FLUSH_BYTE);
            out_error <= 1'b0;
            x         <= x_sh;
            cnt       <= cnt + 1'b1;
            if (cnt == LAST_FLUSH_BYTE) begin
              coder_state <= STATE_FLOOR;
              fsm         <= S_IDLE;
            end
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/rans_enc_checker.sv */
// Port-level checker for the rANS encoder, bound to its top level.
// Depends on rans_pkg for the action codes.
module rans_enc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_valid,
  input logic                          item_ready,
  input logic [rans_pkg::ACT_W-1:0]    item_action,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [rans_pkg::BYTE_W-1:0]   res_byte,
  input logic                          res_last,
  input logic                          res_error
);
  import rans_pkg::*;

  // Hold a stalled result transaction
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte)
      && $stable(res_last) && $stable(res_error))
    else $error("result changed while stalled");

  // An error transaction is alone: last set and no byte
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_error |-> res_last && (res_byte == '0))
    else $error("malformed error transaction");

  // A load never produces a result
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item_action == ACT_LOAD) && !res_valid
      |=> !res_valid)
    else $error("result after load");

  // A flush keeps the encoder busy
  assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && (item_action == ACT_FLUSH) |=> !item_ready)
    else $error("item accepted during flush");

  // Reset leaves no result pending
  assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind rans_byte_encoder rans_enc_checker u_rans_enc_checker (
  .clk         (clk),
  .rst         (rst),
  .item_valid  (items.valid),
  .item_ready  (items.ready),
  .item_action (items.action),
  .res_valid   (results.valid),
  .res_ready   (results.ready),
  .res_byte    (results.out_byte),
  .res_last    (results.last),
  .res_error   (results.error)
);

/* bench/tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for rans_byte_encoder: table loads, symbol encodes and flushes.
// Depends on rans_pkg and the channel interfaces in rans_if; checks every byte against
// its own prediction of the coder.
module tb;
  import rans_pkg::*;

  localparam int PREC = 15;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last;
    logic              error;
  } stream_rec_t;

  logic clk;
  logic rst;

  rans_item_if   items_ch ();
  rans_result_if results_ch ();

  rans_byte_encoder #(
    .PRECISION_BITS(PREC),
    .ALPHABET_SIZE (256)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_ch),
    .results(results_ch)
  );

  // Predicted coder contents
  logic [STATE_W-1:0] coder_x;
  logic [FREQ_W-1:0]  freq_mem [256];
  logic [FREQ_W-1:0]  cum_mem  [256];
  logic [FREQ_W-1:0]  run_sum;
  bit                 loaded   [256];
  int                 loaded_syms [$];

  // Stream bytes and error markers still owed by the encoder
  stream_rec_t stream_q [$];

  int send_idle_pct;
  int recv_stall_pct;
  int sent_count;
  int mismatch_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Append one owed transaction to the tail of the stream
  function automatic void queue_owed(stream_rec_t rec);
    stream_q = {stream_q, rec};
  endfunction

  // Queue the transactions one input item causes and advance the coder
  function automatic void advance_coder(logic [ACT_W-1:0] act, logic [SYM_W-1:0] sym,
                                        logic [FREQ_W-1:0] freq);
    logic [63:0]       x;
    logic [63:0]       xmax;
    logic [63:0]       f;
    logic [63:0]       c;
    logic [BYTE_W-1:0] renorm [4];
    int                n;
    n = 0;
    case (act)
      ACT_LOAD: begin
        if (sym == '0) run_sum = '0;
        freq_mem[sym] = freq;
        cum_mem[sym]  = run_sum;
        run_sum       = run_sum + freq;
      end
      ACT_ENCODE: begin
        f = 64'(freq_mem[sym]);
        c = 64'(cum_mem[sym]);
        if (f == 0) begin
          queue_owed('{out_byte: '0, last: 1'b1, error: 1'b1});
        end else begin
          x    = 64'(coder_x);
          xmax = ((64'(STATE_FLOOR) >> PREC) << 8) * f;
          while (x >= xmax && n < 4) begin
            renorm[n] = x[7:0];
            n++;
            x = x >> 8;
          end
          for (int i = 0; i < n; i++)
            queue_owed('{out_byte: renorm[i], last: (i == n - 1), error: 1'b0});
          x       = ((x / f) << PREC) + (x % f) + c;
          coder_x = x[STATE_W-1:0];
        end
      end
      ACT_FLUSH: begin
        for (int i = 0; i < 4; i++)
          queue_owed('{out_byte: coder_x[8*i +: 8], last: (i == 3), error: 1'b0});
        coder_x = STATE_FLOOR;
      end
      default: ;
    endcase
  endfunction

  // Send one input item, idling first at random, and predict once it is taken
  task automatic send_item(logic [ACT_W-1:0] act, logic [SYM_W-1:0] sym,
                           logic [FREQ_W-1:0] freq);
    while ($urandom_range(99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid     <= 1'b1;
    items_ch.action    <= act;
    items_ch.symbol    <= sym;
    items_ch.frequency <= freq;
    do @(posedge clk); while (!items_ch.ready);
    advance_coder(act, sym, freq);
    if (act == ACT_LOAD && !loaded[sym]) begin
      loaded[sym] = 1'b1;
      loaded_syms = {loaded_syms, int'(sym)};
    end
    if (act != ACT_UNUSED) sent_count++;
  endtask

  function automatic logic [SYM_W-1:0] pick_loaded();
    return SYM_W'(loaded_syms[$urandom_range(loaded_syms.size() - 1)]);
  endfunction

  // Throttle the result channel
  always @(posedge clk) begin
    results_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each result transaction with the oldest owed one
  always @(posedge clk) begin
    stream_rec_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (stream_q.size() == 0) begin
        mismatch_count++;
        $error("unexpected result transaction: out_byte %0h last %0b error %0b",
               results_ch.out_byte, results_ch.last, results_ch.error);
      end else begin
        want = stream_q.pop_front();
        if (results_ch.out_byte !== want.out_byte) begin
          mismatch_count++;
          $error("out_byte: expected %0h actual %0h", want.out_byte, results_ch.out_byte);
        end
        if (results_ch.last !== want.last) begin
          mismatch_count++;
          $error("last: expected %0b actual %0b", want.last, results_ch.last);
        end
        if (results_ch.error !== want.error) begin
          mismatch_count++;
          $error("error: expected %0b actual %0b", want.error, results_ch.error);
        end
      end
    end
  end

  // Load a table that sums to 2^15, renormalize by one byte on each of two encodes
  task automatic test_table_and_encode();
    send_item(ACT_LOAD, 8'd0, 16'd16384);
    send_item(ACT_LOAD, 8'd1, 16'd8192);
    send_item(ACT_LOAD, 8'd2, 16'd8191);
    send_item(ACT_LOAD, 8'd3, 16'd1);
    send_item(ACT_LOAD, 8'd4, 16'd0);
    send_item(ACT_ENCODE, 8'd3, 16'hFFFF);
    send_item(ACT_ENCODE, 8'd0, 16'h0000);
    send_item(ACT_ENCODE, 8'd1, 16'h5A5A);
    send_item(ACT_ENCODE, 8'd2, 16'hA5A5);
  endtask

  // Encode a symbol loaded with frequency zero: one error transaction; then a nonzero one
  task automatic test_zero_frequency();
    send_item(ACT_ENCODE, 8'd4, 16'd0);
    send_item(ACT_ENCODE, 8'd3, 16'd0);
  endtask

  // Flush, encode without renormalization, drop an unused action, flush again
  task automatic test_flush_and_unused_action();
    send_item(ACT_FLUSH, 8'hFF, 16'hFFFF);
    send_item(ACT_ENCODE, 8'd0, 16'd0);
    send_item(ACT_UNUSED, 8'hFF, 16'hFFFF);
    send_item(ACT_FLUSH, 8'h00, 16'h0000);
  endtask

  // Frequencies past 2^15 and a top symbol with a wrapped running sum
  task automatic test_oversized_table();
    send_item(ACT_LOAD, 8'd0, 16'hFFFF);
    send_item(ACT_LOAD, 8'd1, 16'd32768);
    send_item(ACT_LOAD, 8'd255, 16'hFFFF);
    send_item(ACT_ENCODE, 8'd255, 16'd0);
    send_item(ACT_ENCODE, 8'd1, 16'd0);
    send_item(ACT_ENCODE, 8'd0, 16'd0);
    send_item(ACT_FLUSH, 8'd0, 16'd0);
  endtask

  // Reload symbols from zero up with frequencies that sum to 2^15
  task automatic load_random_table();
    int k;
    int left;
    int f;
    k    = $urandom_range(8, 2);
    left = 1 << PREC;
    for (int i = 0; i < k; i++) begin
      if (i == k - 1) f = left;
      else if ($urandom_range(9) == 0) f = 0;
      else f = $urandom_range(left - (k - 1 - i), 1);
      left -= f;
      send_item(ACT_LOAD, SYM_W'(i), FREQ_W'(f));
    end
  endtask

  // Mostly whole messages (at times a new table, then encodes and a flush), the rest stray items
  task automatic test_random_streams(int n_items);
    int goal;
    goal = sent_count + n_items;
    while (sent_count < goal) begin
      if ($urandom_range(99) < 70) begin
        if ($urandom_range(2) == 0) load_random_table();
        repeat ($urandom_range(12, 3))
          send_item(ACT_ENCODE, pick_loaded(), FREQ_W'($urandom));
        send_item(ACT_FLUSH, SYM_W'($urandom), FREQ_W'($urandom));
      end else begin
        case ($urandom_range(3))
          0: send_item(ACT_UNUSED, SYM_W'($urandom), FREQ_W'($urandom));
          1: send_item(ACT_LOAD, SYM_W'($urandom), FREQ_W'($urandom));
          2: send_item(ACT_ENCODE, pick_loaded(), FREQ_W'($urandom));
          default: send_item(ACT_FLUSH, SYM_W'($urandom), FREQ_W'($urandom));
        endcase
      end
    end
  endtask

  initial begin
    items_ch.valid     <= 1'b0;
    items_ch.action    <= ACT_LOAD;
    items_ch.symbol    <= '0;
    items_ch.frequency <= '0;
    rst                <= 1'b1;
    coder_x        = STATE_FLOOR;
    run_sum        = '0;
    sent_count     = 0;
    send_idle_pct  = 10;
    recv_stall_pct = 78;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_table_and_encode();
    test_zero_frequency();
    test_flush_and_unused_action();
    test_oversized_table();
    test_random_streams(70);

    send_idle_pct  = 78;
    recv_stall_pct = 10;
    test_random_streams(70);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_streams(70);

    // Drain what is owed, then hold for stray transactions
    items_ch.valid <= 1'b0;
    while (stream_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
